### rtl/core/lba_pkg.sv
// Package for the linked block allocator: sizes, codes, payload and control types.
package lba_pkg;

  // Table size and longest run that one request may ask for.
  localparam int NUM_BLOCKS = 64;
  localparam int MAX_RUN    = 16;

  // Address width of the link table, widths of the fixed payload fields and of the step counter.
  localparam int BLK_W = $clog2(NUM_BLOCKS);
  localparam int IDX_W = 6;
  localparam int LEN_W = 5;
  localparam int CNT_W = $clog2(MAX_RUN + 1);

  // Operation codes of an input transaction.
  typedef enum logic {
    KIND_LINK  = 1'b0,
    KIND_ALLOC = 1'b1
  } kind_t;

  // Input transaction payload.
  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  block;
    logic [IDX_W-1:0]  next_block;
    logic              next_is_end;
    logic [LEN_W-1:0]  run_length;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic              granted;
    logic [IDX_W-1:0]  start_block;
    logic [IDX_W-1:0]  end_block;
  } out_item_t;

  // One entry of the link table.
  typedef struct packed {
    logic              tail;
    logic [IDX_W-1:0]  succ;
  } link_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_link;
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done_grant;
    logic refuse;
    logic out_free;
  } sts_t;

endpackage

### rtl/core/lba_in_if.sv
// Valid/ready channel that carries input transactions.
interface lba_in_if;
  logic              valid;
  logic              ready;
  lba_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/lba_out_if.sv
// Valid/ready channel that carries result transactions.
interface lba_out_if;
  logic               valid;
  logic               ready;
  lba_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/linked_block_allocator.sv
// Top level of the linked block allocator: controller, datapath and channel wiring.
//
// The allocator holds one next-block link per block and an allocation cursor that
// starts at block 0. A link transaction (kind 0) writes one block's successor or
// marks it as the chain tail when it is accepted, giving no result. An allocate
// transaction (kind 1) walks the chain from the cursor, one link-table read per
// cycle, and returns one result: granted with the start and end blocks when the
// requested number of blocks all have successors, else refused with zero blocks.
// An allocation occupies the block until its result is written; its walk steps
// over at most MAX_RUN links, fewer when the chain ends early, and the single read
// port of the link table paces it. The last cycle of the walk repeats for as long as
// the previous result has not been taken. After reset every block is a chain tail.
module linked_block_allocator (
  input  logic      clk,
  input  logic      rst_n,
  lba_in_if.sink    in_chan,
  lba_out_if.source out_chan
);

  lba_pkg::cmd_t cmd;
  lba_pkg::sts_t sts;

  // Transaction sequencing.
  lba_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Link table, walker and result register.
  lba_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_chan.data),
    .cmd      (cmd),
    .sts      (sts),
    .out_chan (out_chan)
  );

endmodule

### rtl/core/lba_datapath.sv
// Datapath of the linked block allocator: link table, cursor, chain walker and result register.
module lba_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  lba_pkg::in_item_t in_data,
  input  lba_pkg::cmd_t     cmd,
  output lba_pkg::sts_t     sts,
  lba_out_if.source         out_chan
);

  // Link table memory; entries never written read as chain tail via the valid bits.
  lba_pkg::link_t                   mem [lba_pkg::NUM_BLOCKS];
  logic [lba_pkg::NUM_BLOCKS-1:0]   valid_r;
  lba_pkg::link_t                   rd_entry_r;
  logic                             rd_vld_r;
  logic [lba_pkg::BLK_W-1:0]        rd_addr;

  // Walk state.
  logic [lba_pkg::IDX_W-1:0]        cursor_r;
  logic [lba_pkg::IDX_W-1:0]        b_r;
  logic [lba_pkg::IDX_W-1:0]        last_r;
  logic [lba_pkg::CNT_W-1:0]        cnt_r;
  logic [lba_pkg::LEN_W-1:0]        len_r;
  logic                             len_ok_r;

  // Result register.
  logic                             out_valid_r;
  lba_pkg::out_item_t               out_data_r;

  lba_pkg::link_t                   wr_entry;
  logic                             wr_en;
  logic                             cur_tail;

  // Entry to write: out-of-range successors and explicit tails both mark the tail.
  always_comb begin
    wr_entry.tail = in_data.next_is_end || (int'(in_data.next_block) >= lba_pkg::NUM_BLOCKS);
    wr_entry.succ = wr_entry.tail ? '0 : in_data.next_block;
    wr_en         = cmd.write_link && (int'(in_data.block) < lba_pkg::NUM_BLOCKS);
  end

  // Read address: the successor while stepping, the cursor on a new request, else hold.
  always_comb begin
    if (cmd.step) begin
      rd_addr = rd_entry_r.succ[lba_pkg::BLK_W-1:0];
    end else if (cmd.load) begin
      rd_addr = cursor_r[lba_pkg::BLK_W-1:0];
    end else begin
      rd_addr = b_r[lba_pkg::BLK_W-1:0];
    end
  end

  // Memory write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_data.block[lba_pkg::BLK_W-1:0]] <= wr_entry;
    end
    rd_entry_r <= mem[rd_addr];
    rd_vld_r   <= valid_r[rd_addr];
  end

  // Per-entry written flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[in_data.block[lba_pkg::BLK_W-1:0]] <= 1'b1;
    end
  end

  // Status toward the controller; a request of illegal length is never granted.
  always_comb begin
    cur_tail       = !rd_vld_r || rd_entry_r.tail;
    sts.done_grant = len_ok_r && (int'(cnt_r) == int'(len_r));
    sts.refuse     = !len_ok_r || cur_tail;
    sts.out_free   = !out_valid_r || out_chan.ready;
  end

  // Chain walker registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b_r      <= cursor_r;
      last_r   <= cursor_r;
      cnt_r    <= '0;
      len_r    <= in_data.run_length;
      len_ok_r <= (in_data.run_length != '0) &&
                  (int'(in_data.run_length) <= lba_pkg::MAX_RUN);
    end else if (cmd.step) begin
      last_r <= b_r;
      b_r    <= rd_entry_r.succ;
      cnt_r  <= cnt_r + lba_pkg::CNT_W'(1);
    end
  end

  // Allocation cursor moves past the run on a grant.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
    end else if (cmd.finish && sts.done_grant) begin
      cursor_r <= b_r;
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r.granted     <= sts.done_grant;
      out_data_r.start_block <= sts.done_grant ? cursor_r : '0;
      out_data_r.end_block   <= sts.done_grant ? last_r : '0;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // A refused result never names a block.
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.granted) |->
      (out_data_r.start_block == '0 && out_data_r.end_block == '0))
    else $error("refused result carries nonzero blocks");

  // The cursor moves only when a grant is written to the result register.
  a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.finish && sts.done_grant) |=> $stable(cursor_r))
    else $error("cursor changed without a grant");

  // The step count never passes the requested length.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (int'(cnt_r) < int'(len_r)))
    else $error("walk stepped past the requested length");

endmodule

### rtl/core/lba_ctrl.sv
// Controller of the linked block allocator: accepts transactions and sequences the chain walk.
module lba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  lba_in_if.sink        in_chan,
  input  lba_pkg::sts_t sts,
  output lba_pkg::cmd_t cmd
);

  lba_pkg::state_t state_r;
  lba_pkg::state_t state_nxt;
  logic            accept;
  logic            walking;
  logic            ending;

  assign in_chan.ready = (state_r == lba_pkg::ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign walking       = (state_r == lba_pkg::ST_WALK);
  assign ending        = sts.done_grant || sts.refuse;

  // Commands: a link write completes at acceptance; an allocation walks one link a cycle.
  always_comb begin
    cmd.write_link = accept && (in_chan.data.kind == lba_pkg::KIND_LINK);
    cmd.load       = accept && (in_chan.data.kind == lba_pkg::KIND_ALLOC);
    cmd.step       = walking && !ending;
    cmd.finish     = walking && ending && sts.out_free;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lba_pkg::ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = lba_pkg::ST_WALK;
        end
      end
      lba_pkg::ST_WALK: begin
        if (cmd.finish) begin
          state_nxt = lba_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lba_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lba_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A result is only written when the result register can take it.
  a_finish_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.out_free)
    else $error("result written while the result register was full");

  // Stepping and finishing never happen together.
  a_step_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.step && cmd.finish))
    else $error("step and finish in the same cycle");

  // An allocation transaction leads to the walk in the next cycle.
  a_load_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == lba_pkg::ST_WALK))
    else $error("allocation accepted without starting the walk");

endmodule
